// ----- hw/rtl/ipd_pkg.sv -----
// Package for the impact peak detector: field widths, fixed-point constants,
// register reset values and configuration register indexes.
// No dependencies; all other files but ipd_isqrt refer to it by scoped name.
`default_nettype none

package ipd_pkg;

    // Field widths of the channel payloads and registers.
    localparam int ACC_W  = 16;   // raw accelerometer axis field
    localparam int TIME_W = 32;   // millisecond timestamp
    localparam int MG_W   = 22;   // magnitudes in mg
    localparam int WIN_W  = 16;   // window length register
    localparam int CFG_W  = 32;   // configuration write data
    localparam int IDX_W  = 2;    // configuration register index

    // Fixed-point constants: 49 mg per count, 1 g with 4 fraction bits.
    localparam int unsigned MG_PER_COUNT = 49;
    localparam int unsigned ONE_G_Q4     = 16000;
    localparam int unsigned ROUND_HALF   = 8;

    // Register reset values.
    localparam logic [MG_W-1:0]   THRESHOLD_RST = MG_W'(8000);
    localparam logic [TIME_W-1:0] DEBOUNCE_RST  = TIME_W'(2000);
    localparam logic [WIN_W-1:0]  WINDOW_RST    = WIN_W'(300);

    // Configuration register indexes.
    typedef enum logic [IDX_W-1:0] {
        CFG_THRESHOLD = 2'd0,
        CFG_DEBOUNCE  = 2'd1,
        CFG_WINDOW    = 2'd2
    } t_cfg_index;

endpackage

`default_nettype wire

// ----- hw/rtl/ipd_in_if.sv -----
// Input channel of the impact peak detector: one accelerometer sample per
// transaction. Depends on ipd_pkg for the field widths.
`default_nettype none

interface ipd_in_if;
    logic                              valid;
    logic                              ready;
    logic signed [ipd_pkg::ACC_W-1:0]  accel_x;
    logic signed [ipd_pkg::ACC_W-1:0]  accel_y;
    logic signed [ipd_pkg::ACC_W-1:0]  accel_z;
    logic [ipd_pkg::TIME_W-1:0]        time_ms;

    modport source (output valid, accel_x, accel_y, accel_z, time_ms, input ready);
    modport sink   (input valid, accel_x, accel_y, accel_z, time_ms, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/ipd_out_if.sv -----
// Output channel of the impact peak detector: one result per transaction.
// Depends on ipd_pkg for the field widths.
`default_nettype none

interface ipd_out_if;
    logic                         valid;
    logic                         ready;
    logic [ipd_pkg::MG_W-1:0]     dynamic_mg;
    logic                         window_open;
    logic                         impact_valid;
    logic [ipd_pkg::MG_W-1:0]     impact_peak_mg;
    logic [ipd_pkg::TIME_W-1:0]   impact_time_ms;
    logic [ipd_pkg::MG_W-1:0]     session_peak_mg;

    modport source (output valid, dynamic_mg, window_open, impact_valid, impact_peak_mg,
                    impact_time_ms, session_peak_mg, input ready);
    modport sink   (input valid, dynamic_mg, window_open, impact_valid, impact_peak_mg,
                    impact_time_ms, session_peak_mg, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/impact_peak_detector_top.sv -----
// Impact peak detector top level: sequencer, squaring multiplier, scaling,
// window and debounce logic, output register. Depends on ipd_pkg, ipd_in_if,
// ipd_out_if and ipd_isqrt.
//
// Usage: each transaction on i_in carries one three-axis sample and its
// millisecond timestamp; each produces exactly one transaction on o_out with
// the sample's dynamic magnitude |length - 1 g| in mg, the window flag, an
// impact record when the sample closed a peak window, and the session peak.
// The user must set the three registers (threshold, debounce, window length)
// on i_cfg, one per cycle, with no sample in flight; the block does not check.
//
// Timing: the block works on one sample at a time. The three axes are
// squared on one shared multiplier, the square root produces one bit per
// cycle, the finished root is handed to the sequencer, then scaling,
// rounding and the window decision follow as separate steps. i_in.ready
// returns once the decision step has loaded the output register, so a new
// sample is taken only after the previous one's result is complete. The
// square root loop is the longest step.
//
// Reset (synchronous, active low) empties the output register, closes any
// window, clears the last impact time and the session peak, and restores
// the register defaults. If the receiver stalls, the finished result waits
// in the output register; the next sample is still accepted and computed,
// and its decision step waits until the register is free.
`default_nettype none

module impact_peak_detector_top #(
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [ipd_pkg::IDX_W-1:0]   i_cfg_index,
    input  wire logic [ipd_pkg::CFG_W-1:0]   i_cfg_data,
    ipd_in_if.sink                           i_in,
    ipd_out_if.source                        o_out
);

    localparam int SB     = SAMPLE_BITS;
    localparam int SQ_W   = 2 * SB;
    localparam int SUM_W  = SQ_W + 2;
    localparam int RAD_W  = SUM_W + 8;        // sum of squares times 256
    localparam int ROOT_W = RAD_W / 2;
    localparam int MG_W   = ROOT_W + 6;       // root times 49
    localparam int MW     = ipd_pkg::MG_W;
    localparam int TW     = ipd_pkg::TIME_W;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_SQUARE = 6'b000010,
        ST_ROOT   = 6'b000100,
        ST_SCALE  = 6'b001000,
        ST_ROUND  = 6'b010000,
        ST_DECIDE = 6'b100000
    } t_state;

    function automatic logic [SB-1:0] f_abs(input logic [SB-1:0] v);
        f_abs = v[SB-1] ? (~v + 1'b1) : v;
    endfunction

    // Configuration registers.
    logic [MW-1:0]                r_threshold;
    logic [TW-1:0]                r_debounce;
    logic [ipd_pkg::WIN_W-1:0]    r_window;

    // Sequencer and detector state.
    t_state        r_state;
    logic [1:0]    r_axis;
    logic          r_in_window;
    logic [TW-1:0] r_win_end;
    logic [MW-1:0] r_win_peak;
    logic [TW-1:0] r_last;
    logic [MW-1:0] r_session;

    // Datapath registers.
    logic [SB-1:0]    r_abs_x, r_abs_y, r_abs_z;
    logic [TW-1:0]    r_time;
    logic [SQ_W-1:0]  r_sq;
    logic [SUM_W-1:0] r_sum, n_sum;
    logic [MG_W-1:0]  r_mg;
    logic [MW-1:0]    r_dyn;

    // Output register.
    logic          r_out_valid;
    logic [MW-1:0] r_o_dyn;
    logic          r_o_window;
    logic          r_o_impact;
    logic [MW-1:0] r_o_peak;
    logic [TW-1:0] r_o_time;
    logic [MW-1:0] r_o_session;

    logic             in_accept;
    logic [SB-1:0]    sq_operand;
    logic [SQ_W-1:0]  sq_product;
    logic             sqrt_start;
    logic             sqrt_done;
    logic [ROOT_W-1:0] sqrt_root;
    logic [31:0]      mg_wide;
    logic [31:0]      dev;
    logic [31:0]      dev_rnd;
    logic             decide_go;
    logic [MW-1:0]    peak_upd;
    logic [TW-1:0]    since_end;
    logic [TW-1:0]    since_last;
    logic             win_close;
    logic             win_open;
    logic [MW-1:0]    session_upd;

    assign i_in.ready = (r_state == ST_IDLE);
    assign in_accept  = i_in.valid && i_in.ready;

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= ipd_pkg::THRESHOLD_RST;
            r_debounce  <= ipd_pkg::DEBOUNCE_RST;
            r_window    <= ipd_pkg::WINDOW_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ipd_pkg::CFG_THRESHOLD: r_threshold <= i_cfg_data[MW-1:0];
                ipd_pkg::CFG_DEBOUNCE:  r_debounce  <= i_cfg_data[TW-1:0];
                ipd_pkg::CFG_WINDOW:    r_window    <= i_cfg_data[ipd_pkg::WIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Shared squaring multiplier: axis 0, 1, 2 are squared in successive
    // cycles and each product is registered and added to the sum in the next cycle.
    always_comb begin
        case (r_axis)
            2'd0:    sq_operand = r_abs_x;
            2'd1:    sq_operand = r_abs_y;
            default: sq_operand = r_abs_z;
        endcase
        sq_product = SQ_W'(sq_operand) * SQ_W'(sq_operand);
        n_sum      = (r_axis == 2'd0) ? '0 : r_sum + SUM_W'(r_sq);
    end

    assign sqrt_start = (r_state == ST_SQUARE) && (r_axis == 2'd3);

    ipd_isqrt #(
        .RAD_W (RAD_W)
    ) u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sqrt_start),
        .i_radicand ({n_sum, 8'h00}),
        .o_done     (sqrt_done),
        .o_root     (sqrt_root)
    );

    // Distance from 1 g with 4 fraction bits, rounded half up to whole mg.
    always_comb begin
        mg_wide = 32'(r_mg);
        if (mg_wide >= 32'(ipd_pkg::ONE_G_Q4)) begin
            dev = mg_wide - 32'(ipd_pkg::ONE_G_Q4);
        end else begin
            dev = 32'(ipd_pkg::ONE_G_Q4) - mg_wide;
        end
        dev_rnd = dev + 32'(ipd_pkg::ROUND_HALF);
    end

    // Window decision. An open window tracks the peak and closes on the
    // first sample whose signed distance to the end time is not negative.
    // A closed window opens when the magnitude reaches the threshold and
    // the debounce time since the last impact has passed.
    always_comb begin
        decide_go   = (r_state == ST_DECIDE) && (!r_out_valid || o_out.ready);
        peak_upd    = (r_dyn > r_win_peak) ? r_dyn : r_win_peak;
        since_end   = r_time - r_win_end;
        since_last  = r_time - r_last;
        win_close   = r_in_window && !since_end[TW-1];
        win_open    = !r_in_window && (r_dyn >= r_threshold) && (since_last >= r_debounce);
        session_upd = (win_close && (peak_upd > r_session)) ? peak_upd : r_session;
    end

    // Sequencer and detector state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_axis      <= '0;
            r_in_window <= 1'b0;
            r_win_end   <= '0;
            r_win_peak  <= '0;
            r_last      <= '0;
            r_session   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // A new result fills the output register; otherwise it empties
            // once the receiver takes it.
            if (decide_go) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_accept) begin
                        r_state <= ST_SQUARE;
                        r_axis  <= '0;
                    end
                end
                ST_SQUARE: begin
                    r_axis <= r_axis + 1'b1;
                    if (r_axis == 2'd3) begin
                        r_state <= ST_ROOT;
                    end
                end
                ST_ROOT: begin
                    if (sqrt_done) begin
                        r_state <= ST_SCALE;
                    end
                end
                ST_SCALE: r_state <= ST_ROUND;
                ST_ROUND: r_state <= ST_DECIDE;
                ST_DECIDE: begin
                    if (decide_go) begin
                        r_state     <= ST_IDLE;
                        if (r_in_window) begin
                            r_win_peak <= peak_upd;
                            if (win_close) begin
                                r_in_window <= 1'b0;
                                r_last      <= r_time;
                                r_session   <= session_upd;
                            end
                        end else if (win_open) begin
                            r_in_window <= 1'b1;
                            r_win_end   <= r_time + TW'(r_window);
                            r_win_peak  <= r_dyn;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Datapath and output payload registers.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_abs_x <= f_abs(i_in.accel_x[SB-1:0]);
            r_abs_y <= f_abs(i_in.accel_y[SB-1:0]);
            r_abs_z <= f_abs(i_in.accel_z[SB-1:0]);
            r_time  <= i_in.time_ms;
        end
        if (r_state == ST_SQUARE) begin
            r_sq  <= sq_product;
            r_sum <= n_sum;
        end
        if (r_state == ST_SCALE) begin
            r_mg <= MG_W'(sqrt_root) * MG_W'(ipd_pkg::MG_PER_COUNT);
        end
        if (r_state == ST_ROUND) begin
            r_dyn <= dev_rnd[MW+3:4];
        end
        if (decide_go) begin
            r_o_dyn     <= r_dyn;
            r_o_window  <= r_in_window ? !win_close : win_open;
            r_o_impact  <= win_close;
            r_o_peak    <= win_close ? peak_upd : '0;
            r_o_time    <= win_close ? r_time : '0;
            r_o_session <= session_upd;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.dynamic_mg      = r_o_dyn;
    assign o_out.window_open     = r_o_window;
    assign o_out.impact_valid    = r_o_impact;
    assign o_out.impact_peak_mg  = r_o_peak;
    assign o_out.impact_time_ms  = r_o_time;
    assign o_out.session_peak_mg = r_o_session;

    // The sequencer state stays a single hot bit.
    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("sequencer state is not one-hot");

    // The square root only finishes while the sequencer waits for it.
    a_sqrt_done_in_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sqrt_done |-> (r_state == ST_ROOT))
        else $error("square root finished outside the root state");

    // An accepted sample starts squaring with the first axis.
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == ST_SQUARE) && (r_axis == 2'd0))
        else $error("accepted sample did not start the squaring step");

    // A recorded impact closes the window and never exceeds the session peak.
    a_impact_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_o_impact) |-> (!r_o_window && (r_o_session >= r_o_peak)))
        else $error("impact result inconsistent with window or session peak");

    // Without an impact the impact fields read zero.
    a_no_impact_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_o_impact) |-> ((r_o_peak == '0) && (r_o_time == '0)))
        else $error("impact fields not zero without an impact");

endmodule

`default_nettype wire

// ----- hw/rtl/ipd_isqrt.sv -----
// Iterative integer square root, one root bit per cycle (restoring method).
// Standalone; instantiated by impact_peak_detector_top.
`default_nettype none

module ipd_isqrt #(
    parameter int RAD_W = 42
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [RAD_W-1:0]      i_radicand,
    output logic                       o_done,
    output logic [RAD_W/2-1:0]         o_root
);

    localparam int ROOT_W = RAD_W / 2;
    localparam int CNT_W  = $clog2(ROOT_W + 1);

    logic [RAD_W-1:0]  r_rad,  n_rad;
    logic [ROOT_W:0]   r_rem,  n_rem;
    logic [ROOT_W-1:0] r_root, n_root;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_done;

    logic [ROOT_W+2:0] rem_shift;
    logic [ROOT_W+2:0] trial;
    logic [ROOT_W+2:0] diff;
    logic              fits;

    // The remainder takes the next two radicand bits; the trial subtrahend
    // is four times the partial root plus one.
    always_comb begin
        rem_shift = {r_rem, r_rad[RAD_W-1 -: 2]};
        trial     = {1'b0, r_root, 2'b01};
        diff      = rem_shift - trial;
        fits      = (rem_shift >= trial);
        n_rad     = {r_rad[RAD_W-3:0], 2'b00};
        if (fits) begin
            n_rem  = diff[ROOT_W:0];
            n_root = {r_root[ROOT_W-2:0], 1'b1};
        end else begin
            n_rem  = rem_shift[ROOT_W:0];
            n_root = {r_root[ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_cnt  <= CNT_W'(ROOT_W);
            r_done <= 1'b0;
        end else if (r_cnt != '0) begin
            r_cnt  <= r_cnt - 1'b1;
            r_done <= (r_cnt == CNT_W'(1));
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_cnt != '0) begin
            r_rad  <= n_rad;
            r_rem  <= n_rem;
            r_root <= n_root;
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

`default_nettype wire

// ----- tb/ipd_impact_checker.sv -----
// Result checker for the impact peak detector testbench: watches the sample and result
// channels and the register port, predicts every result and compares it field by field.
// Depends on ipd_pkg, ipd_in_if and ipd_out_if.
`timescale 1ns / 100ps

module ipd_impact_checker #(
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [ipd_pkg::IDX_W-1:0]   i_cfg_index,
    input  wire logic [ipd_pkg::CFG_W-1:0]   i_cfg_data,
    ipd_in_if                                i_samples,
    ipd_out_if                               i_results,
    output int                               o_mismatches,
    output int                               o_outstanding
);

    localparam int MG_W   = ipd_pkg::MG_W;
    localparam int TIME_W = ipd_pkg::TIME_W;
    localparam int REPORT_MAX = 10;

    typedef struct packed {
        logic [MG_W-1:0]   dynamic_mg;
        logic              window_open;
        logic              impact_valid;
        logic [MG_W-1:0]   impact_peak_mg;
        logic [TIME_W-1:0] impact_time_ms;
        logic [MG_W-1:0]   session_peak_mg;
    } t_impact_result;

    t_impact_result    expected_results[$];

    // Shadow registers and detector state. The counters start at zero.
    logic [MG_W-1:0]        thr_mg;
    logic [TIME_W-1:0]      holdoff_ms;
    logic [ipd_pkg::WIN_W-1:0] window_len_ms;
    logic                   window_active;
    logic [TIME_W-1:0]      window_close_ms;
    logic [MG_W-1:0]        window_max_mg;
    logic [TIME_W-1:0]      last_hit_ms;
    logic [MG_W-1:0]        session_max_mg;
    int                     result_count;

    // Magnitude of one axis in counts, using only the low SAMPLE_BITS bits.
    function automatic logic [31:0] axis_counts(input logic [ipd_pkg::ACC_W-1:0] raw);
        logic signed [31:0] wide;
        wide = signed'(32'(raw));
        wide = (wide <<< (32 - SAMPLE_BITS)) >>> (32 - SAMPLE_BITS);
        return (wide < 0) ? 32'(-wide) : 32'(wide);
    endfunction

    // |vector length - 1 g| in mg, rounded from 4 fraction bits.
    function automatic logic [MG_W-1:0] sample_dyn_mg(input logic [ipd_pkg::ACC_W-1:0] x,
                                                      input logic [ipd_pkg::ACC_W-1:0] y,
                                                      input logic [ipd_pkg::ACC_W-1:0] z);
        logic [63:0] ax, ay, az;
        logic [63:0] radicand;
        logic [63:0] root;
        logic [63:0] trial;
        logic [63:0] len_q4;
        logic [63:0] off_q4;
        ax = 64'(axis_counts(x));
        ay = 64'(axis_counts(y));
        az = 64'(axis_counts(z));
        radicand = (ax * ax + ay * ay + az * az) << 8;
        root = '0;
        // Bit-by-bit floor square root; the radicand stays below 2^42.
        for (int b = 21; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= radicand) begin
                root = trial;
            end
        end
        len_q4 = root * 64'(ipd_pkg::MG_PER_COUNT);
        if (len_q4 >= 64'(ipd_pkg::ONE_G_Q4)) begin
            off_q4 = len_q4 - 64'(ipd_pkg::ONE_G_Q4);
        end else begin
            off_q4 = 64'(ipd_pkg::ONE_G_Q4) - len_q4;
        end
        return MG_W'((off_q4 + 64'(ipd_pkg::ROUND_HALF)) >> 4);
    endfunction

    // Runs one sample through the window and debounce logic and queues its result.
    task automatic predict_result(input logic [ipd_pkg::ACC_W-1:0] x,
                                  input logic [ipd_pkg::ACC_W-1:0] y,
                                  input logic [ipd_pkg::ACC_W-1:0] z,
                                  input logic [TIME_W-1:0] now);
        t_impact_result    res;
        logic [MG_W-1:0]   dyn;
        logic [TIME_W-1:0] since_end;
        logic [TIME_W-1:0] since_hit;
        dyn = sample_dyn_mg(x, y, z);
        res = '0;
        since_end = now - window_close_ms;
        since_hit = now - last_hit_ms;
        if (window_active) begin
            if (dyn > window_max_mg) begin
                window_max_mg = dyn;
            end
            // Signed difference: the window is over once now has reached its end.
            if (!since_end[TIME_W-1]) begin
                res.impact_valid   = 1'b1;
                res.impact_peak_mg = window_max_mg;
                res.impact_time_ms = now;
                if (window_max_mg > session_max_mg) begin
                    session_max_mg = window_max_mg;
                end
                window_active = 1'b0;
                last_hit_ms   = now;
            end
        end else if (dyn >= thr_mg && since_hit >= holdoff_ms) begin
            window_active   = 1'b1;
            window_close_ms = now + TIME_W'(window_len_ms);
            window_max_mg   = dyn;
        end
        res.dynamic_mg      = dyn;
        res.window_open     = window_active;
        res.session_peak_mg = session_max_mg;
        expected_results.push_back(res);
    endtask

    always @(posedge i_clk) begin
        t_impact_result want;
        t_impact_result got;
        if (!i_rst_n) begin
            thr_mg          = ipd_pkg::THRESHOLD_RST;
            holdoff_ms      = ipd_pkg::DEBOUNCE_RST;
            window_len_ms   = ipd_pkg::WINDOW_RST;
            window_active   = 1'b0;
            window_close_ms = '0;
            window_max_mg   = '0;
            last_hit_ms     = '0;
            session_max_mg  = '0;
            expected_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    ipd_pkg::CFG_THRESHOLD: thr_mg        = i_cfg_data[MG_W-1:0];
                    ipd_pkg::CFG_DEBOUNCE:  holdoff_ms    = i_cfg_data[TIME_W-1:0];
                    ipd_pkg::CFG_WINDOW:    window_len_ms = i_cfg_data[ipd_pkg::WIN_W-1:0];
                    default: ;
                endcase
            end
            if (i_results.valid && i_results.ready) begin
                got = '{i_results.dynamic_mg, i_results.window_open, i_results.impact_valid,
                        i_results.impact_peak_mg, i_results.impact_time_ms,
                        i_results.session_peak_mg};
                result_count++;
                if (expected_results.size() == 0) begin
                    o_mismatches++;
                    if (o_mismatches <= REPORT_MAX) begin
                        $display("%0t: result %0d arrived with nothing expected", $time,
                                 result_count);
                    end
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        o_mismatches++;
                        if (o_mismatches <= REPORT_MAX) begin
                            $display("%0t: result %0d mismatch", $time, result_count);
                            $display("  expected dyn=%0d open=%0b imp=%0b peak=%0d t=%0d sess=%0d",
                                     want.dynamic_mg, want.window_open, want.impact_valid,
                                     want.impact_peak_mg, want.impact_time_ms,
                                     want.session_peak_mg);
                            $display("  actual   dyn=%0d open=%0b imp=%0b peak=%0d t=%0d sess=%0d",
                                     got.dynamic_mg, got.window_open, got.impact_valid,
                                     got.impact_peak_mg, got.impact_time_ms,
                                     got.session_peak_mg);
                        end
                    end
                end
            end
            if (i_samples.valid && i_samples.ready) begin
                predict_result(i_samples.accel_x, i_samples.accel_y, i_samples.accel_z,
                               i_samples.time_ms);
            end
        end
        o_outstanding <= expected_results.size();
    end

endmodule

// ----- tb/impact_peak_detector_top_tb.sv -----
// Top of the impact peak detector testbench: clock, reset, register writes and sample
// stimulus with random idling on both channels; the verdict comes from ipd_impact_checker.
// Depends on ipd_pkg, ipd_in_if, ipd_out_if, impact_peak_detector_top and ipd_impact_checker.
`timescale 1ns / 100ps

module impact_peak_detector_top_tb;

    localparam int SAMPLE_BITS   = 16;
    localparam int RESET_CYCLES  = 12;
    // Waiting this long after the last result leaves the block empty before registers
    // change or the run ends.
    localparam int SETTLE_CYCLES = 40;
    // The watchdog allows many times the longest sender gap plus the longest receiver
    // stall plus the block's own processing time without any transaction.
    localparam int STALL_LIMIT   = 4000;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS   = 125;

    // The port has a fourth index that maps to no register; writes to it must be ignored.
    localparam logic [ipd_pkg::IDX_W-1:0] CFG_UNUSED = 2'd3;

    localparam logic signed [ipd_pkg::ACC_W-1:0] AX_MIN = 16'sh8000;
    localparam logic signed [ipd_pkg::ACC_W-1:0] AX_MAX = 16'sh7FFF;
    localparam logic [ipd_pkg::MG_W-1:0]        THR_MAX = 22'd2781034;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n;
    logic                        cfg_we;
    logic [ipd_pkg::IDX_W-1:0]   cfg_index;
    logic [ipd_pkg::CFG_W-1:0]   cfg_data;
    logic                        idling_on;
    int                          mismatches;
    int                          outstanding;
    int                          quiet_cycles;

    ipd_in_if  sample_ch ();
    ipd_out_if result_ch ();

    impact_peak_detector_top #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in        (sample_ch),
        .o_out       (result_ch)
    );

    ipd_impact_checker #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_samples     (sample_ch),
        .i_results     (result_ch),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Idle stretch length: mostly none or short, sometimes medium, rarely long.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 70) begin
            return $urandom_range(0, 2);
        end else if (roll < 95) begin
            return $urandom_range(3, 8);
        end
        return $urandom_range(20, 80);
    endfunction

    // Offers one sample and holds it until the block takes it. Between samples the
    // channel may go idle with junk on the payload, so gaps land on every phase of the
    // block's square-root loop.
    task automatic push_sample(input logic signed [ipd_pkg::ACC_W-1:0] x,
                               input logic signed [ipd_pkg::ACC_W-1:0] y,
                               input logic signed [ipd_pkg::ACC_W-1:0] z,
                               input logic [ipd_pkg::TIME_W-1:0] t);
        int unsigned gap;
        sample_ch.valid   <= 1'b1;
        sample_ch.accel_x <= x;
        sample_ch.accel_y <= y;
        sample_ch.accel_z <= z;
        sample_ch.time_ms <= t;
        do @(posedge i_clk); while (!sample_ch.ready);
        gap = idling_on ? pick_gap() : 0;
        if (gap != 0) begin
            sample_ch.valid   <= 1'b0;
            sample_ch.accel_x <= $urandom;
            sample_ch.accel_y <= $urandom;
            sample_ch.accel_z <= $urandom;
            sample_ch.time_ms <= $urandom;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Drops valid, waits for a clock edge so the checker has counted the last sample, waits
    // for every expected result, then lets the block go quiet.
    task automatic drain();
        sample_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [ipd_pkg::IDX_W-1:0] idx,
                             input logic [ipd_pkg::CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge i_clk);
    endtask

    // Writes all three registers back to back, preceded by a write to the unused index.
    task automatic program_regs(input logic [ipd_pkg::CFG_W-1:0] thr,
                                input logic [ipd_pkg::CFG_W-1:0] holdoff,
                                input logic [ipd_pkg::CFG_W-1:0] win);
        write_reg(CFG_UNUSED, $urandom);
        write_reg(ipd_pkg::CFG_THRESHOLD, thr);
        write_reg(ipd_pkg::CFG_DEBOUNCE, holdoff);
        write_reg(ipd_pkg::CFG_WINDOW, win);
        cfg_we <= 1'b0;
    endtask

    // One axis value: quiet readings near zero, impact-sized swings, raw bits or rails.
    function automatic logic signed [ipd_pkg::ACC_W-1:0] pick_axis(input int unsigned kind);
        logic signed [ipd_pkg::ACC_W-1:0] mag;
        case (kind)
            0: return ipd_pkg::ACC_W'($urandom_range(0, 8)) - 16'sd4;
            1: begin
                mag = ipd_pkg::ACC_W'($urandom_range(100, 32767));
                return $urandom_range(0, 1) ? -mag : mag;
            end
            2: return ipd_pkg::ACC_W'($urandom);
            default: begin
                case ($urandom_range(0, 4))
                    0: return AX_MIN;
                    1: return AX_MAX;
                    2: return 16'sd0;
                    3: return -16'sd1;
                    default: return 16'sd1;
                endcase
            end
        endcase
    endfunction

    // Random register settings, the extremes among them.
    task automatic program_random();
        logic [ipd_pkg::CFG_W-1:0] thr, holdoff, win;
        case ($urandom_range(0, 5))
            0: thr = '0;
            1: thr = 32'(THR_MAX);
            2: thr = $urandom;
            3: thr = $urandom_range(20000, 300000);
            default: thr = $urandom_range(200, 20000);
        endcase
        case ($urandom_range(0, 5))
            0: holdoff = '0;
            1: holdoff = 32'hFFFF_FFFF;
            2: holdoff = $urandom;
            3: holdoff = $urandom_range(300, 3000);
            default: holdoff = $urandom_range(0, 300);
        endcase
        case ($urandom_range(0, 5))
            0: win = '0;
            1: win = 32'h0000_FFFF;
            2: win = $urandom;
            default: win = $urandom_range(1, 200);
        endcase
        program_regs(thr, holdoff, win);
    endtask

    // Well-formed traffic for the most part: timestamps stepping by the 10 ms sample
    // period, quiet readings around 1 g broken by impact bursts. The rest repeats or
    // skips timestamps and throws in raw and full-scale samples.
    task automatic run_random_phase(input int unsigned count);
        logic [ipd_pkg::TIME_W-1:0]       now;
        logic signed [ipd_pkg::ACC_W-1:0] x, y, z;
        int unsigned                      roll;
        int unsigned                      kind;
        case ($urandom_range(0, 3))
            0: now = 32'hFFFF_FFFF - $urandom_range(0, 3000);
            1: now = $urandom_range(0, 5000);
            default: now = $urandom;
        endcase
        for (int unsigned n = 0; n < count; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 80) begin
                now = now + 32'd10;
            end else if (roll < 90) begin
                now = now + $urandom_range(0, 30);
            end else if (roll < 95) begin
                now = now;
            end else begin
                now = now + $urandom;
            end
            roll = $urandom_range(0, 99);
            kind = (roll < 55) ? 0 : (roll < 80) ? 1 : (roll < 92) ? 2 : 3;
            x = pick_axis(kind);
            y = pick_axis(kind);
            z = pick_axis(kind);
            // A resting sensor reads about 20 counts on one axis.
            if (kind == 0) begin
                z = z + ($urandom_range(0, 1) ? 16'sd20 : -16'sd20);
            end
            push_sample(x, y, z, now);
        end
    endtask

    // Result side: ready held for a while, then dropped for a random stall when idling.
    initial begin
        result_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            int unsigned stall;
            result_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge i_clk);
            stall = idling_on ? pick_gap() : 0;
            if (stall != 0) begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
        end
    end

    // Watchdog: any cycle with a transaction on either channel restarts the count.
    always @(posedge i_clk) begin
        if (!i_rst_n || (sample_ch.valid && sample_ch.ready) ||
            (result_ch.valid && result_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == STALL_LIMIT) begin
                $display("impact_peak_detector_top regression: fail");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n           <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_index         <= ipd_pkg::CFG_THRESHOLD;
        cfg_data          <= '0;
        idling_on         <= 1'b1;
        sample_ch.valid   <= 1'b0;
        sample_ch.accel_x <= '0;
        sample_ch.accel_y <= '0;
        sample_ch.accel_z <= '0;
        sample_ch.time_ms <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Register defaults: threshold 8000 mg, debounce 2000 ms, window 300 ms.
        // A zero sample reads exactly 1000 mg and (0,0,20) reads exactly 20 mg.
        push_sample(16'sd0, 16'sd0, 16'sd0, 32'd0);
        // Full scale but one millisecond short of the first debounce.
        push_sample(AX_MIN, AX_MIN, AX_MIN, 32'd1999);
        // Debounce met exactly: opens a window that ends at 2300.
        push_sample(AX_MAX, AX_MAX, AX_MAX, 32'd2000);
        push_sample(AX_MIN, 16'sd0, 16'sd0, 32'd2100);
        // Same magnitude as the opening sample: a tie leaves the peak alone, and the
        // window is still open one millisecond before its end.
        push_sample(AX_MAX, AX_MAX, AX_MAX, 32'd2299);
        // At the window end the impact is recorded.
        push_sample(16'sd0, 16'sd0, 16'sd20, 32'd2300);
        push_sample(AX_MIN, AX_MIN, AX_MIN, 32'd2301);
        push_sample(16'sd0, 16'sd0, -16'sd20, 32'd4299);
        push_sample(AX_MAX, AX_MIN, 16'sd0, 32'd4300);
        push_sample(16'sd1, -16'sd1, 16'sd1, 32'd4600);
        drain();

        // Threshold 1000 with garbage above bit 21, no debounce, zero-length window
        // written with garbage in the upper half.
        program_regs(32'hFFC0_03E8, 32'd0, 32'hFFFF_0000);
        // A threshold tie opens the window; the opening sample never closes it even
        // with a zero window, the next one does, just before the timestamp wrap.
        push_sample(16'sd0, 16'sd0, 16'sd0, 32'hFFFF_FFFE);
        push_sample(16'sd0, 16'sd0, 16'sd0, 32'hFFFF_FFFF);
        push_sample(16'sd0, 16'sd0, 16'sd20, 32'd0);
        push_sample(16'sd0, 16'sd0, 16'sd0, 32'd0);
        push_sample(-16'sd1, 16'sd0, 16'sd0, 32'd0);
        drain();

        // Zero threshold, largest debounce, largest window (upper bits masked off).
        // With the last impact at 0, only a timestamp of all ones meets the debounce;
        // the window end then wraps to 0xFFFE.
        program_regs(32'd0, 32'hFFFF_FFFF, 32'h1234_FFFF);
        push_sample(16'sd0, 16'sd0, 16'sd20, 32'hFFFF_FFFE);
        push_sample(16'sd0, 16'sd0, 16'sd20, 32'hFFFF_FFFF);
        push_sample(AX_MAX, 16'sd0, 16'sd0, 32'h0000_0010);
        push_sample(16'sd0, 16'sd0, 16'sd0, 32'h0000_FFFD);
        push_sample(16'sd0, 16'sd0, 16'sd0, 32'h0000_FFFE);
        push_sample(AX_MIN, AX_MIN, AX_MIN, 32'h8000_FFFE);
        drain();

        // Random phases; every third one runs with both channels free of idling.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            idling_on <= (phase % 3) != 0;
            program_random();
            run_random_phase(PHASE_ITEMS);
            drain();
        end

        if (mismatches == 0 && outstanding == 0) begin
            $display("impact_peak_detector_top regression: pass");
        end else begin
            $display("impact_peak_detector_top regression: fail");
        end
        $finish;
    end

endmodule
